// ----- design/arot_pkg.sv -----
// Shared types, codes and defaults for the address range owner table.
package arot_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;

	localparam int ADDR_W  = 64;
	localparam int OWNER_W = 8;
	localparam int TAG_W   = 64;

	localparam logic [1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [1:0] FUNC_INSERT = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
	localparam logic [2:0] STAT_OVERLAP   = 3'd2;
	localparam logic [2:0] STAT_MISMATCH  = 3'd3;
	localparam logic [2:0] STAT_FULL      = 3'd4;

	typedef struct packed {
		logic               valid;
		logic [ADDR_W-1:0]  lo;
		logic [ADDR_W-1:0]  hi;
		logic [OWNER_W-1:0] owner;
		logic [TAG_W-1:0]   tag;
	} arot_entry_t;

	localparam int ENTRY_W = $bits(arot_entry_t);

	typedef struct packed {
		logic overlap;
		logic exact;
	} arot_match_t;

endpackage

// ----- design/address_range_owner_table_top.sv -----
// Top level of the address range owner table: sequencer, scan and result register.
//
// Usage: a request transaction on in_valid/in_ready carries func (lookup, insert,
// remove), the address or range start, end_address, owner_id, tag_in and ip_past.
// Every request yields exactly one result transaction on out_valid/out_ready with
// status, owner_out and tag_out (owner and tag are zero unless a lookup hits).
//
// Timing: the result is registered at the end of the scan. One stored entry is read
// from the table RAM per cycle and tested by the single range comparator; the RAM
// read data is registered, and the sequencer then commits the result in its commit
// step. in_ready is high only while the sequencer is idle, which it reaches again
// with the commit, so a new request is not accepted before the last one commits.
//
// Reset: arst_n clears all control state, then a clearing pass writes every slot
// invalid, one slot per cycle; no request is taken then.
//
// Stall: the result sits in an output register. A new request is accepted while it
// waits; if that request finishes before the old result is taken, the sequencer
// holds in its commit step until out_ready frees the register.
module address_range_owner_table_top
	import arot_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [ADDR_W-1:0]  address,
	input  logic [ADDR_W-1:0]  end_address,
	input  logic [OWNER_W-1:0] owner_id,
	input  logic [TAG_W-1:0]   tag_in,
	input  logic               ip_past,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [OWNER_W-1:0] owner_out,
	output logic [TAG_W-1:0]   tag_out
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

	// Sequencer states
	localparam logic [1:0] S_CLEAR  = 2'd0;
	localparam logic [1:0] S_IDLE   = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_COMMIT = 2'd3;

	logic [1:0] state_q;

	// Latched request
	logic [1:0]         func_q;
	logic [ADDR_W-1:0]  qry_lo_q;
	logic [ADDR_W-1:0]  qry_hi_q;
	logic [OWNER_W-1:0] owner_q;
	logic [TAG_W-1:0]   tag_q;

	// Scan counters: clearing pass, read issue, and the entry now in the comparator
	logic [CNT_W-1:0] clr_q;
	logic [CNT_W-1:0] issue_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	// Scan findings, each the lowest slot of its kind
	logic               hit_q;
	logic [OWNER_W-1:0] hit_owner_q;
	logic [TAG_W-1:0]   hit_tag_q;
	logic               exact_q;
	logic [IDX_W-1:0]   exact_idx_q;
	logic [OWNER_W-1:0] exact_owner_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;

	// Output register
	logic               out_valid_q;
	logic [2:0]         status_q;
	logic [OWNER_W-1:0] owner_out_q;
	logic [TAG_W-1:0]   tag_out_q;

	// RAM and comparator wiring
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	arot_entry_t      ram_wdata;
	arot_entry_t      ram_rdata;
	logic [ENTRY_W-1:0] ram_rdata_raw;
	arot_match_t      cmp_res;

	// Commit decision
	logic               out_free;
	logic               commit;
	logic [2:0]         res_status;
	logic [OWNER_W-1:0] res_owner;
	logic [TAG_W-1:0]   res_tag;
	logic               do_insert;
	logic               do_remove;
	logic               in_fire;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign commit   = (state_q == S_COMMIT) && out_free;

	arot_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES),
		.AW    (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = arot_entry_t'(ram_rdata_raw);

	arot_cmp u_cmp (
		.entry  (ram_rdata),
		.qry_lo (qry_lo_q),
		.qry_hi (qry_hi_q),
		.result (cmp_res)
	);

	// Work out the answer from the scan findings
	always_comb begin
		res_status = STAT_NOT_FOUND;
		res_owner  = '0;
		res_tag    = '0;
		do_insert  = 1'b0;
		do_remove  = 1'b0;
		unique case (func_q)
			FUNC_LOOKUP: begin
				if (hit_q) begin
					res_status = STAT_OK;
					res_owner  = hit_owner_q;
					res_tag    = hit_tag_q;
				end
			end
			FUNC_INSERT: begin
				// overlap takes precedence over a full table
				if (hit_q) begin
					res_status = STAT_OVERLAP;
				end else if (free_q) begin
					res_status = STAT_OK;
					do_insert  = 1'b1;
				end else begin
					res_status = STAT_FULL;
				end
			end
			FUNC_REMOVE: begin
				if (!hit_q) begin
					res_status = STAT_NOT_FOUND;
				end else if (!exact_q || (exact_owner_q != owner_q)) begin
					res_status = STAT_MISMATCH;
				end else begin
					res_status = STAT_OK;
					do_remove  = 1'b1;
				end
			end
			default: begin
				res_status = STAT_NOT_FOUND;
			end
		endcase
	end

	// Table write port: clearing pass, insert into the lowest free slot, or removal
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = free_idx_q;
		ram_wdata = '0;
		priority if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q[IDX_W-1:0];
		end else if (commit && do_insert) begin
			ram_we          = 1'b1;
			ram_waddr       = free_idx_q;
			ram_wdata.valid = 1'b1;
			ram_wdata.lo    = qry_lo_q;
			ram_wdata.hi    = qry_hi_q;
			ram_wdata.owner = owner_q;
			ram_wdata.tag   = tag_q;
		end else if (commit && do_remove) begin
			ram_we    = 1'b1;
			ram_waddr = exact_idx_q;
		end else begin
			ram_we = 1'b0;
		end
	end

	// Sequencer and scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			exact_q   <= 1'b0;
			free_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CNT_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						issue_q   <= '0;
						rd_vld_s1 <= 1'b0;
						hit_q     <= 1'b0;
						exact_q   <= 1'b0;
						free_q    <= 1'b0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					// issue the next read while the last one is tested
					if (issue_q != CNT_END) begin
						issue_q <= issue_q + 1'b1;
					end
					rd_vld_s1 <= (issue_q != CNT_END);
					rd_idx_s1 <= issue_q[IDX_W-1:0];
					if (rd_vld_s1) begin
						if (cmp_res.overlap && !hit_q) begin
							hit_q <= 1'b1;
						end
						if (cmp_res.exact && !exact_q) begin
							exact_q     <= 1'b1;
							exact_idx_q <= rd_idx_s1;
						end
						if (!ram_rdata.valid && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= rd_idx_s1;
						end
						if (rd_idx_s1 == IDX_LAST) begin
							state_q <= S_COMMIT;
						end
					end
				end
				S_COMMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload of the scan findings and the latched request
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q   <= func;
			owner_q  <= owner_id;
			tag_q    <= tag_in;
			if (func == FUNC_LOOKUP) begin
				// a point lookup is the range [x, x]; ip_past steps back one, wrapping
				qry_lo_q <= ip_past ? (address - 1'b1) : address;
				qry_hi_q <= ip_past ? (address - 1'b1) : address;
			end else begin
				qry_lo_q <= address;
				qry_hi_q <= end_address;
			end
		end
		if ((state_q == S_SCAN) && rd_vld_s1) begin
			if (cmp_res.overlap && !hit_q) begin
				hit_owner_q <= ram_rdata.owner;
				hit_tag_q   <= ram_rdata.tag;
			end
			if (cmp_res.exact && !exact_q) begin
				exact_owner_q <= ram_rdata.owner;
			end
		end
	end

	// Output register: load on commit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q    <= res_status;
			owner_out_q <= res_owner;
			tag_out_q   <= res_tag;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign owner_out = owner_out_q;
	assign tag_out   = tag_out_q;

endmodule

// ----- design/arot_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module arot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/arot_cmp.sv -----
// Range comparator: overlap and exact-match test of one stored entry.
module arot_cmp
	import arot_pkg::*;
(
	input  arot_entry_t        entry,
	input  logic [ADDR_W-1:0]  qry_lo,
	input  logic [ADDR_W-1:0]  qry_hi,
	output arot_match_t        result
);

	// Closed ranges overlap when each one starts no later than the other ends.
	always_comb begin
		result.overlap = entry.valid && (entry.lo <= qry_hi) && (qry_lo <= entry.hi);
		result.exact   = entry.valid && (entry.lo == qry_lo) && (entry.hi == qry_hi);
	end

endmodule
